### rtl/ptmp_pkg.sv
// Package for the pager time message parser.
// Label text, label automaton step, digit and pair helpers, sync and register codes.
// No dependencies.
package ptmp_pkg;

    localparam int unsigned DIGIT_COUNT = 12;
    localparam int unsigned LABEL_LEN   = 14;
    localparam int unsigned CAP_W       = 21;

    localparam logic [3:0]  LABEL_DONE  = 4'(LABEL_LEN);
    localparam logic [3:0]  DIGITS_FULL = 4'(DIGIT_COUNT);
    localparam logic [11:0] YEAR_BASE   = 12'd2000;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_Y    = 8'h59;

    localparam logic [1:0] REG_OWN_CAPCODE   = 2'd0;
    localparam logic [1:0] REG_UTC_CAPCODE   = 2'd1;
    localparam logic [1:0] REG_LOCAL_CAPCODE = 2'd2;

    localparam logic [CAP_W-1:0] OWN_CAPCODE_RST   = 21'd0;
    localparam logic [CAP_W-1:0] UTC_CAPCODE_RST   = 21'd216;
    localparam logic [CAP_W-1:0] LOCAL_CAPCODE_RST = 21'd224;

    typedef enum logic [1:0] {
        SYNC_NONE  = 2'd0,
        SYNC_UTC   = 2'd1,
        SYNC_LOCAL = 2'd2
    } sync_kind_t;

    typedef logic [3:0] digit_t;

    // digit view handed from the scanner to the result stage
    typedef struct packed {
        logic                          complete;
        digit_t [DIGIT_COUNT-1:0]      digits;
    } scan_t;

    function automatic logic [7:0] label_char(input logic [3:0] k);
        logic [7:0] ch;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3: ch = CHAR_Y;
            4'd4, 4'd5, 4'd10, 4'd11: ch = 8'h4D;
            4'd6, 4'd7:  ch = 8'h44;
            4'd8, 4'd9:  ch = 8'h48;
            4'd12, 4'd13: ch = 8'h53;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // one step of the prefix automaton; fail chain collapsed to closed form
    function automatic logic [3:0] label_step(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] nk;
        if (c == label_char(k))
            nk = k + 4'd1;
        else if (c == CHAR_Y)
            nk = (k == 4'd4) ? 4'd4 : 4'd1;
        else
            nk = 4'd0;
        return nk;
    endfunction

    function automatic logic [7:0] pair_value(input digit_t hi, input digit_t lo);
        return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
    endfunction

endpackage

### rtl/ptmp_scan.sv
// Label automaton, digit capture and digit store for the time message parser.
// Depends on ptmp_pkg.
module ptmp_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        char_code,
    input  logic              last,
    output ptmp_pkg::scan_t   scan
);
    import ptmp_pkg::*;

    logic [3:0]                label_reg, label_next;
    logic [3:0]                count_reg, count_next;
    digit_t [DIGIT_COUNT-1:0]  store_reg;

    logic       found;
    logic       is_digit;
    logic       capture;
    logic [3:0] count_inc;
    digit_t     digit_val;

    assign found     = (label_reg == LABEL_DONE);
    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign capture   = found && is_digit && (count_reg < DIGITS_FULL);
    assign digit_val = 4'(char_code - CHAR_ZERO);
    assign count_inc = count_reg + {3'b000, capture};

    always_comb
    begin
        label_next = label_reg;
        count_next = count_reg;
        if (advance)
        begin
            if (last)
            begin
                label_next = 4'd0;
                count_next = 4'd0;
            end
            else
            begin
                if (!found)
                    label_next = label_step(label_reg, char_code);
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= 4'd0;
            count_reg <= 4'd0;
        end
        else
        begin
            label_reg <= label_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && capture)
            store_reg[count_reg] <= digit_val;
    end

    always_comb
    begin
        scan.complete = found && (count_inc == DIGITS_FULL);
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            scan.digits[i] = (capture && count_reg == 4'(i)) ? digit_val : store_reg[i];
        end
    end

    a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
        label_reg <= LABEL_DONE)
        else $error("label progress out of range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DIGITS_FULL)
        else $error("digit count out of range");

    a_count_after_label: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 4'd0) |-> found)
        else $error("digits captured before label found");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last) |=> (label_reg == 4'd0 && count_reg == 4'd0))
        else $error("end of message did not clear scan state");

endmodule

### rtl/ptmp_result.sv
// Timestamp decode, range checks, capcode matching and result register.
// Depends on ptmp_pkg.
module ptmp_result (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  ptmp_pkg::scan_t             scan,
    input  logic [ptmp_pkg::CAP_W-1:0]  capcode,
    input  logic [ptmp_pkg::CAP_W-1:0]  own_capcode,
    input  logic [ptmp_pkg::CAP_W-1:0]  utc_capcode,
    input  logic [ptmp_pkg::CAP_W-1:0]  local_capcode,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        time_valid,
    output logic [11:0]                 year,
    output logic [3:0]                  month,
    output logic [4:0]                  day,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [1:0]                  sync_kind,
    output logic                        to_own
);
    import ptmp_pkg::*;

    logic       valid_reg, valid_next;
    logic       tv_reg;
    logic [11:0] year_reg;
    logic [3:0] month_reg;
    logic [4:0] day_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;
    logic [5:0] second_reg;
    sync_kind_t kind_reg, kind_next;
    logic       own_reg;

    logic [7:0] yy, mo, dd, hh, mi, ss;
    logic       ok;

    assign yy = pair_value(scan.digits[0],  scan.digits[1]);
    assign mo = pair_value(scan.digits[2],  scan.digits[3]);
    assign dd = pair_value(scan.digits[4],  scan.digits[5]);
    assign hh = pair_value(scan.digits[6],  scan.digits[7]);
    assign mi = pair_value(scan.digits[8],  scan.digits[9]);
    assign ss = pair_value(scan.digits[10], scan.digits[11]);

    assign ok = scan.complete && (mo >= 8'd1) && (mo <= 8'd12) && (dd >= 8'd1) &&
                (dd <= 8'd31) && (hh <= 8'd23) && (mi <= 8'd59) && (ss <= 8'd59);

    always_comb
    begin
        kind_next = SYNC_NONE;
        if (ok)
        begin
            if (capcode == utc_capcode)
                kind_next = SYNC_UTC;
            else if (capcode == local_capcode)
                kind_next = SYNC_LOCAL;
        end
    end

    assign free       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (free ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tv_reg     <= ok;
            year_reg   <= ok ? YEAR_BASE + {4'b0000, yy} : YEAR_BASE;
            month_reg  <= ok ? mo[3:0] : 4'd0;
            day_reg    <= ok ? dd[4:0] : 5'd0;
            hour_reg   <= ok ? hh[4:0] : 5'd0;
            minute_reg <= ok ? mi[5:0] : 6'd0;
            second_reg <= ok ? ss[5:0] : 6'd0;
            kind_reg   <= kind_next;
            own_reg    <= (capcode == own_capcode);
        end
    end

    assign out_valid  = valid_reg;
    assign time_valid = tv_reg;
    assign year       = year_reg;
    assign month      = month_reg;
    assign day        = day_reg;
    assign hour       = hour_reg;
    assign minute     = minute_reg;
    assign second     = second_reg;
    assign sync_kind  = kind_reg;
    assign to_own     = own_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !tv_reg) |-> (kind_reg == SYNC_NONE && month_reg == 4'd0 &&
                                     day_reg == 5'd0 && year_reg == YEAR_BASE))
        else $error("invalid result carries fields");

    a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && tv_reg) |-> (month_reg >= 4'd1 && month_reg <= 4'd12 &&
                                    day_reg >= 5'd1 && hour_reg <= 5'd23))
        else $error("valid result out of range");

endmodule

### rtl/pager_time_message_parser.sv
// Top level of the pager time message parser: input register, capcode registers,
// scanner and result stage. Depends on ptmp_pkg, ptmp_scan, ptmp_result.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | in_valid / in_stall | char_code, capcode, last
//  output   | out_valid/out_stall | time_valid, year, month, day, hour, minute,
//           |                     | second, sync_kind, to_own
//  config   | cfg_we              | cfg_index, cfg_data
//
// One character per cycle while in_stall is low. The result of the transaction
// carrying the last character goes through the input register, then the result
// register. Non-final characters never wait on out_stall; a final
// character waits in the input register only while a previous result is held.
// Reset clears scan state and loads capcodes 0, 216 and 224.
module pager_time_message_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  char_code,
    input  logic [ptmp_pkg::CAP_W-1:0]  capcode,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        time_valid,
    output logic [11:0]                 year,
    output logic [3:0]                  month,
    output logic [4:0]                  day,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [1:0]                  sync_kind,
    output logic                        to_own,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ptmp_pkg::CAP_W-1:0]  cfg_data
);
    import ptmp_pkg::*;

    logic [CAP_W-1:0] own_reg, utc_reg, local_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_char_reg;
    logic [CAP_W-1:0] s1_cap_reg;
    logic             s1_last_reg;

    logic  in_accept;
    logic  s1_adv;
    logic  out_free;
    scan_t scan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg   <= OWN_CAPCODE_RST;
            utc_reg   <= UTC_CAPCODE_RST;
            local_reg <= LOCAL_CAPCODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_CAPCODE:   own_reg   <= cfg_data;
                REG_UTC_CAPCODE:   utc_reg   <= cfg_data;
                REG_LOCAL_CAPCODE: local_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_adv        = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall      = s1_valid_reg && !s1_adv;
    assign in_accept     = in_valid && !in_stall;
    assign s1_valid_next = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg <= char_code;
            s1_cap_reg  <= capcode;
            s1_last_reg <= last;
        end
    end

    ptmp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .char_code (s1_char_reg),
        .last      (s1_last_reg),
        .scan      (scan)
    );

    ptmp_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (s1_adv && s1_last_reg),
        .scan          (scan),
        .capcode       (s1_cap_reg),
        .own_capcode   (own_reg),
        .utc_capcode   (utc_reg),
        .local_capcode (local_reg),
        .free          (out_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .time_valid    (time_valid),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .sync_kind     (sync_kind),
        .to_own        (to_own)
    );

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid && out_stall))
        else $error("input stalled without a held result");

    a_last_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=> out_valid)
        else $error("final character produced no result");

endmodule
